[hdl/gsm_pkg.sv]
// shared types and constants for the golden-section mppt step core
// no dependencies; used by golden_section_mppt_step_core

package gsm_pkg;

    // golden ratio fraction, unsigned q0.16
    localparam logic [15:0] PHI_Q16 = 16'd40503;

    localparam logic [15:0] START_LOW_RESET  = 16'd0;
    localparam logic [15:0] START_HIGH_RESET = 16'd65535;

    // configuration register indexes
    localparam logic CFG_START_LOW  = 1'b0;
    localparam logic CFG_START_HIGH = 1'b1;

    // search phases
    localparam logic [1:0] PH_START    = 2'd0;
    localparam logic [1:0] PH_SECOND   = 2'd1;
    localparam logic [1:0] PH_CONV_RHS = 2'd2;
    localparam logic [1:0] PH_CONV_LHS = 2'd3;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_POWER  = 5'b00010,
        ST_DECIDE = 5'b00100,
        ST_OFFSET = 5'b01000,
        ST_PLACE  = 5'b10000
    } seq_state_t;

endpackage

[hdl/golden_section_mppt_step_core.sv]
// golden-section maximum power point tracker, one step per measurement item
// depends on gsm_pkg for constants and the sequencer state type
//
// result registered after the power, decide, offset and place states; place holds while a previous result is stalled
// a new item is taken only in idle, after the last result is placed; one 16x16
//   multiplier serves both the power product and the probe offset, each taking one pass
// reset (rst_n, async): phase 0, bracket and probes at the register reset values

module golden_section_mppt_step_core (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // array_voltage[15:0], array_current[31:16]
    input  logic        s_tuser,   // restart
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // reference_voltage[15:0], search_phase[17:16]
);

    gsm_pkg::seq_state_t state_reg, state_next;

    logic [15:0] start_low_reg;
    logic [15:0] start_high_reg;

    logic [15:0] volt_reg;
    logic [15:0] curr_reg;
    logic        restart_reg;

    logic [1:0]  phase_reg;
    logic [15:0] bracket_low_reg;
    logic [15:0] bracket_high_reg;
    logic [15:0] left_probe_reg;
    logic [15:0] right_probe_reg;
    logic [31:0] left_power_reg;
    logic [31:0] right_power_reg;
    logic        place_left_reg;

    logic [31:0] prod_reg;
    logic [15:0] mul_a;
    logic [15:0] mul_b;
    logic [15:0] span;

    logic        m_tvalid_reg;
    logic [15:0] m_vref_reg;
    logic [1:0]  m_phase_reg;

    logic        out_free;
    logic [31:0] lp_eff;
    logic [31:0] rp_eff;
    logic [15:0] new_probe;

    assign s_tready = (state_reg == gsm_pkg::ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, m_phase_reg, m_vref_reg};
    assign out_free = !m_tvalid_reg || m_tready;

    // inverted bracket gives a zero span, so the probes land on the bounds
    assign span = (bracket_high_reg >= bracket_low_reg) ?
                  (bracket_high_reg - bracket_low_reg) : 16'd0;

    // shared multiplier operand select
    always_comb
    begin
        if (state_reg == gsm_pkg::ST_OFFSET)
        begin
            mul_a = span;
            mul_b = gsm_pkg::PHI_Q16;
        end
        else
        begin
            mul_a = volt_reg;
            mul_b = curr_reg;
        end
    end

    // powers as seen after recording the newest probe
    assign lp_eff = (phase_reg == gsm_pkg::PH_CONV_LHS) ? prod_reg : left_power_reg;
    assign rp_eff = (phase_reg == gsm_pkg::PH_CONV_RHS) ? prod_reg : right_power_reg;

    assign new_probe = place_left_reg ? (bracket_high_reg - prod_reg[31:16])
                                      : (bracket_low_reg + prod_reg[31:16]);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            gsm_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = gsm_pkg::ST_POWER;
            end
            gsm_pkg::ST_POWER:  state_next = gsm_pkg::ST_DECIDE;
            gsm_pkg::ST_DECIDE: state_next = gsm_pkg::ST_OFFSET;
            gsm_pkg::ST_OFFSET: state_next = gsm_pkg::ST_PLACE;
            gsm_pkg::ST_PLACE:
            begin
                if (out_free)
                    state_next = gsm_pkg::ST_IDLE;
            end
            default: state_next = gsm_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= gsm_pkg::ST_IDLE;
            start_low_reg    <= gsm_pkg::START_LOW_RESET;
            start_high_reg   <= gsm_pkg::START_HIGH_RESET;
            phase_reg        <= gsm_pkg::PH_START;
            bracket_low_reg  <= gsm_pkg::START_LOW_RESET;
            bracket_high_reg <= gsm_pkg::START_HIGH_RESET;
            left_probe_reg   <= gsm_pkg::START_LOW_RESET;
            right_probe_reg  <= gsm_pkg::START_HIGH_RESET;
            left_power_reg   <= 32'd0;
            right_power_reg  <= 32'd0;
            place_left_reg   <= 1'b1;
            m_tvalid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                if (cfg_index == gsm_pkg::CFG_START_LOW)
                    start_low_reg <= cfg_data;
                else
                    start_high_reg <= cfg_data;
            end

            if (state_reg == gsm_pkg::ST_PLACE && out_free)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;

            case (state_reg)
                gsm_pkg::ST_POWER:
                begin
                    if (restart_reg)
                    begin
                        phase_reg        <= gsm_pkg::PH_START;
                        bracket_low_reg  <= start_low_reg;
                        bracket_high_reg <= start_high_reg;
                        left_probe_reg   <= start_low_reg;
                        right_probe_reg  <= start_high_reg;
                        left_power_reg   <= 32'd0;
                        right_power_reg  <= 32'd0;
                    end
                end
                gsm_pkg::ST_DECIDE:
                begin
                    case (phase_reg)
                        gsm_pkg::PH_START:
                        begin
                            place_left_reg <= 1'b1;
                            phase_reg      <= gsm_pkg::PH_SECOND;
                        end
                        gsm_pkg::PH_SECOND:
                        begin
                            left_power_reg <= prod_reg;
                            place_left_reg <= 1'b0;
                            phase_reg      <= gsm_pkg::PH_CONV_RHS;
                        end
                        default:
                        begin
                            if (lp_eff > rp_eff)
                            begin
                                bracket_high_reg <= right_probe_reg;
                                right_probe_reg  <= left_probe_reg;
                                left_power_reg   <= lp_eff;
                                right_power_reg  <= lp_eff;
                                place_left_reg   <= 1'b1;
                                phase_reg        <= gsm_pkg::PH_CONV_LHS;
                            end
                            else
                            begin
                                // equal powers fall here and move the left bound
                                bracket_low_reg <= left_probe_reg;
                                left_probe_reg  <= right_probe_reg;
                                left_power_reg  <= rp_eff;
                                right_power_reg <= rp_eff;
                                place_left_reg  <= 1'b0;
                                phase_reg       <= gsm_pkg::PH_CONV_RHS;
                            end
                        end
                    endcase
                end
                gsm_pkg::ST_PLACE:
                begin
                    if (out_free)
                    begin
                        if (place_left_reg)
                            left_probe_reg <= new_probe;
                        else
                            right_probe_reg <= new_probe;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            volt_reg    <= s_tdata[15:0];
            curr_reg    <= s_tdata[31:16];
            restart_reg <= s_tuser;
        end

        if (state_reg == gsm_pkg::ST_POWER || state_reg == gsm_pkg::ST_OFFSET)
            prod_reg <= {16'd0, mul_a} * {16'd0, mul_b};

        if (state_reg == gsm_pkg::ST_PLACE && out_free)
        begin
            m_vref_reg  <= new_probe;
            m_phase_reg <= phase_reg;
        end
    end

endmodule
